/* design/smseq_pkg.sv */
// ----------------------------------------------------------------------------
// Stepper move sequencer package
// Shared types, register indexes, action codes and the coil phase table.
// ----------------------------------------------------------------------------
package smseq_pkg;

   localparam int STEPS_W  = 16;
   localparam int PERIOD_W = 24;
   localparam int COILS_W  = 4;
   localparam int ACTION_W = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 24;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_TICK       = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_MOVE       = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_MOVE_LIMIT = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_STEPS_PER_REV = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_PERIOD   = 1'd1;

   localparam logic [STEPS_W-1:0]  STEPS_PER_REV_RST = 16'd200;
   localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST   = 24'd10000;

   // coil patterns, bit3 = pin1 .. bit0 = pin4
   localparam logic [COILS_W-1:0] COIL_PH0 = 4'b1010;
   localparam logic [COILS_W-1:0] COIL_PH1 = 4'b0110;
   localparam logic [COILS_W-1:0] COIL_PH2 = 4'b0101;
   localparam logic [COILS_W-1:0] COIL_PH3 = 4'b1001;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [STEPS_W-1:0]  move_steps;
      logic                stop_level;
      logic                limit_level;
   } item_type;

   typedef struct packed {
      logic [COILS_W-1:0] coils;
      logic [STEPS_W-1:0] position;
      logic               moving;
      logic               stepped;
   } result_type;

   typedef struct packed {
      logic [STEPS_W-1:0]  steps_per_rev;
      logic [PERIOD_W-1:0] step_period;
   } cfg_type;

   function automatic logic [COILS_W-1:0] coil_for_phase(input logic [1:0] phase);
      logic [COILS_W-1:0] pattern;
      case (phase)
         2'd0: pattern = COIL_PH0;
         2'd1: pattern = COIL_PH1;
         2'd2: pattern = COIL_PH2;
         2'd3: pattern = COIL_PH3;
         default: pattern = COIL_PH0;
      endcase
      return pattern;
   endfunction

endpackage

/* design/smseq_csr.sv */
// ----------------------------------------------------------------------------
// Stepper move sequencer configuration registers
// Holds steps per revolution and the step period, written by index.
// ----------------------------------------------------------------------------
module smseq_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [smseq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [smseq_pkg::CSR_DATA_W-1:0]  csr_data,
   output smseq_pkg::cfg_type                cfg
);

   logic [smseq_pkg::STEPS_W-1:0]  steps_per_rev_ff, steps_per_rev_in;
   logic [smseq_pkg::PERIOD_W-1:0] step_period_ff, step_period_in;

   assign csr_ready = 1'b1;

   always_comb begin
      steps_per_rev_in = steps_per_rev_ff;
      step_period_in   = step_period_ff;
      if (csr_valid) begin
         case (csr_index)
            smseq_pkg::CSR_STEPS_PER_REV:
               steps_per_rev_in = csr_data[smseq_pkg::STEPS_W-1:0];
            smseq_pkg::CSR_STEP_PERIOD:
               step_period_in = csr_data[smseq_pkg::PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_per_rev_ff <= smseq_pkg::STEPS_PER_REV_RST;
         step_period_ff   <= smseq_pkg::STEP_PERIOD_RST;
      end else begin
         steps_per_rev_ff <= steps_per_rev_in;
         step_period_ff   <= step_period_in;
      end
   end

   assign cfg.steps_per_rev = steps_per_rev_ff;
   assign cfg.step_period   = step_period_ff;

endmodule

/* design/smseq_core.sv */
// ----------------------------------------------------------------------------
// Stepper move sequencer core
// Move state, period timer and position stepping; one transaction per cycle while fire is high.
// ----------------------------------------------------------------------------
module smseq_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  smseq_pkg::item_type    item,
   input  smseq_pkg::cfg_type     cfg,
   output smseq_pkg::result_type  result
);

   logic [smseq_pkg::STEPS_W-1:0]  position_ff, position_in;
   logic [smseq_pkg::STEPS_W-1:0]  remaining_ff, remaining_in;
   logic                           dir_up_ff, dir_up_in;
   logic                           active_ff, active_in;
   logic                           limit_mode_ff, limit_mode_in;
   logic                           stop_match_ff, stop_match_in;
   logic [smseq_pkg::PERIOD_W-1:0] timer_ff, timer_in;
   logic [smseq_pkg::COILS_W-1:0]  coil_ff, coil_in;

   logic [smseq_pkg::STEPS_W:0]    wrap;
   logic [smseq_pkg::STEPS_W:0]    pos_up;
   logic [smseq_pkg::STEPS_W-1:0]  next_pos;
   logic [smseq_pkg::STEPS_W-1:0]  magnitude;
   logic [smseq_pkg::STEPS_W-1:0]  rem_dec;
   logic [smseq_pkg::PERIOD_W-1:0] timer_sum;
   logic                           stepped;

   // zero steps per revolution wraps at the full 16-bit range
   always_comb begin
      wrap = (cfg.steps_per_rev == '0) ? {1'b1, {smseq_pkg::STEPS_W{1'b0}}}
                                       : {1'b0, cfg.steps_per_rev};
      pos_up = {1'b0, position_ff} + 1'b1;
      if (dir_up_ff) begin
         next_pos = (pos_up >= wrap) ? '0 : pos_up[smseq_pkg::STEPS_W-1:0];
      end else if (position_ff == '0) begin
         next_pos = cfg.steps_per_rev - 1'b1;
      end else begin
         next_pos = position_ff - 1'b1;
      end
   end

   assign magnitude = item.move_steps[smseq_pkg::STEPS_W-1] ? (~item.move_steps + 1'b1)
                                                            : item.move_steps;
   assign rem_dec   = remaining_ff - 1'b1;
   assign timer_sum = timer_ff + 1'b1;

   always_comb begin
      position_in   = position_ff;
      remaining_in  = remaining_ff;
      dir_up_in     = dir_up_ff;
      active_in     = active_ff;
      limit_mode_in = limit_mode_ff;
      stop_match_in = stop_match_ff;
      timer_in      = timer_ff;
      coil_in       = coil_ff;
      stepped       = 1'b0;
      if (fire) begin
         case (item.action)
            smseq_pkg::ACT_MOVE, smseq_pkg::ACT_MOVE_LIMIT: begin
               remaining_in = magnitude;
               // keep the direction on a zero-step move
               if (item.move_steps != '0) begin
                  dir_up_in = ~item.move_steps[smseq_pkg::STEPS_W-1];
               end
               limit_mode_in = (item.action == smseq_pkg::ACT_MOVE_LIMIT);
               if (item.action == smseq_pkg::ACT_MOVE_LIMIT) begin
                  stop_match_in = item.stop_level;
               end
               timer_in  = '0;
               active_in = (magnitude != '0);
            end
            smseq_pkg::ACT_TICK: begin
               if (active_ff) begin
                  if (timer_sum >= cfg.step_period) begin
                     timer_in = '0;
                     if (limit_mode_ff && (item.limit_level == stop_match_ff)) begin
                        active_in = 1'b0;
                     end else begin
                        position_in  = next_pos;
                        remaining_in = rem_dec;
                        coil_in      = smseq_pkg::coil_for_phase(next_pos[1:0]);
                        active_in    = (rem_dec != '0);
                        stepped      = 1'b1;
                     end
                  end else begin
                     timer_in = timer_sum;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         remaining_ff  <= '0;
         dir_up_ff     <= 1'b0;
         active_ff     <= 1'b0;
         limit_mode_ff <= 1'b0;
         stop_match_ff <= 1'b0;
         timer_ff      <= '0;
         coil_ff       <= '0;
      end else begin
         position_ff   <= position_in;
         remaining_ff  <= remaining_in;
         dir_up_ff     <= dir_up_in;
         active_ff     <= active_in;
         limit_mode_ff <= limit_mode_in;
         stop_match_ff <= stop_match_in;
         timer_ff      <= timer_in;
         coil_ff       <= coil_in;
      end
   end

   assign result.coils    = coil_in;
   assign result.position = position_in;
   assign result.moving   = active_in;
   assign result.stepped  = stepped;

`ifndef SYNTHESIS
   a_idle_when_done: assert property (@(posedge clock) disable iff (reset)
      (remaining_ff == '0) |-> !active_ff)
      else $error("move active with no steps remaining");

   a_idle_tick_holds: assert property (@(posedge clock) disable iff (reset)
      (fire && (item.action == smseq_pkg::ACT_TICK) && !active_ff)
      |=> ($stable(position_ff) && $stable(timer_ff) && $stable(coil_ff)))
      else $error("idle tick changed state");

   a_coil_phase: assert property (@(posedge clock) disable iff (reset)
      (coil_ff != '0) |-> (coil_ff == smseq_pkg::coil_for_phase(position_ff[1:0])))
      else $error("coil pattern does not match position phase");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !fire |=> ($stable(position_ff) && $stable(remaining_ff) && $stable(active_ff)))
      else $error("state changed without a transaction");
`endif

endmodule

/* design/stepper_move_sequencer.sv */
// ----------------------------------------------------------------------------
// Stepper move sequencer
// Four-wire full-step stepper driver: move commands, tick-driven stepping.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  req      in         req_tvalid/tready  tuser: action; tdata: steps, levels
//  rsp      out        rsp_tvalid/tready  tdata: coils, position, moving, stepped
//  csr      in         csr_valid/ready    csr_index, csr_data
//
//  One transaction per cycle while rsp is ready; each passes the input
//  register, single-pass step logic and the result register in turn.
//  Reset (synchronous) clears both stage valids and the move state.
//  A stalled rsp holds its result; req keeps accepting while the input
//  register is empty or advancing.
// ----------------------------------------------------------------------------
module stepper_move_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [15:0] move_steps, [16] stop_level, [17] limit_level, [23:18] zero
   input  logic [23:0]                       req_tdata,
   // [1:0] action
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [3:0] coils, [19:4] position, [20] moving, [21] stepped, [23:22] zero
   output logic [23:0]                       rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [smseq_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [smseq_pkg::CSR_DATA_W-1:0]  csr_data
);

   smseq_pkg::cfg_type    cfg;
   smseq_pkg::item_type   item_ff, item_in;
   smseq_pkg::result_type result;
   smseq_pkg::result_type rsp_ff;
   logic                  in_valid_ff, in_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  advance;

   smseq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      item_in.action      = req_tuser;
      item_in.move_steps  = req_tdata[15:0];
      item_in.stop_level  = req_tdata[16];
      item_in.limit_level = req_tdata[17];
      in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
   end

   smseq_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers load only on their transaction
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.stepped, rsp_ff.moving, rsp_ff.position,
                        rsp_ff.coils};

endmodule
